@@ rtl/core/mr90_pkg.sv @@
// Package for the matrix rotation unit: shared types, field widths and codes.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps

package mr90_pkg;

    // Fixed field widths of the transaction payload and the dimension registers
    localparam int WORD_W     = 32;
    localparam int OUT_IDX_W  = 6;
    localparam int CFG_DIM_W  = 7;

    // Default geometry of the on-chip store
    localparam int MAX_DIM_DEFAULT = 64;

    // Configuration port
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // Front-to-back queue
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic
    {
        FUNC_LOAD  = 1'b0,
        FUNC_FETCH = 1'b1
    } func_t;

    typedef enum logic [1:0]
    {
        REG_NUM_ROWS  = 2'd0,
        REG_NUM_COLS  = 2'd1,
        REG_DIRECTION = 2'd2
    } reg_idx_t;

    typedef struct packed
    {
        func_t                     func;
        logic signed [WORD_W-1:0]  element_in;
    } mr90_in_t;

    typedef struct packed
    {
        logic signed [WORD_W-1:0]  element_out;
        logic [OUT_IDX_W-1:0]      out_row;
        logic [OUT_IDX_W-1:0]      out_col;
        logic                      last_of_matrix;
    } mr90_out_t;

    // Classified operation handed from front to back (address travels beside it)
    typedef struct packed
    {
        func_t                 op;
        logic [WORD_W-1:0]     data;
        logic [OUT_IDX_W-1:0]  row;
        logic [OUT_IDX_W-1:0]  col;
        logic                  last;
    } mr90_op_t;

endpackage

@@ rtl/core/mr90_front.sv @@
// Front end of the matrix rotation unit: accept transactions, track load and
// fetch positions, and form store addresses. Depends on mr90_pkg.
`timescale 1ns / 1ps

module mr90_front
    import mr90_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEFAULT,
    parameter int CW      = $clog2(MAX_DIM),
    parameter int DIM_W   = $clog2(MAX_DIM + 1),
    parameter int AW      = $clog2(MAX_DIM * MAX_DIM)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  mr90_in_t         cmd,
    input  logic             full,
    input  logic [DIM_W-1:0] rows,
    input  logic [DIM_W-1:0] cols,
    input  logic             dir,
    input  logic             clear,
    output logic             push,
    output mr90_op_t         push_op,
    output logic [AW-1:0]    push_addr
);

    logic [CW-1:0] load_row_reg, load_row_next;
    logic [CW-1:0] load_col_reg, load_col_next;
    logic [CW-1:0] emit_row_reg, emit_row_next;
    logic [CW-1:0] emit_col_reg, emit_col_next;

    logic [DIM_W-1:0] load_col_inc, load_row_inc;
    logic [DIM_W-1:0] emit_col_inc, emit_row_inc;
    logic [DIM_W-1:0] src_row_w, src_col_w;
    logic [CW-1:0]    src_row, src_col;
    logic [CW-1:0]    addr_row, addr_col;
    logic             load_row_end, load_col_end;
    logic             emit_row_end, emit_col_end;
    logic             is_fetch;

    assign push     = start && !full;
    assign is_fetch = (cmd.func == FUNC_FETCH);

    assign load_col_inc = DIM_W'(load_col_reg) + DIM_W'(1);
    assign load_row_inc = DIM_W'(load_row_reg) + DIM_W'(1);
    assign emit_col_inc = DIM_W'(emit_col_reg) + DIM_W'(1);
    assign emit_row_inc = DIM_W'(emit_row_reg) + DIM_W'(1);

    assign load_col_end = (load_col_inc == cols);
    assign load_row_end = (load_row_inc == rows);
    // rotated matrix is cols x rows: emit_row walks cols, emit_col walks rows
    assign emit_col_end = (emit_col_inc == rows);
    assign emit_row_end = (emit_row_inc == cols);

    // Source position in the input matrix for the next rotated element
    assign src_row_w = dir ? DIM_W'(emit_col_reg) : rows - emit_col_inc;
    assign src_col_w = dir ? cols - emit_row_inc : DIM_W'(emit_row_reg);
    assign src_row   = CW'(src_row_w);
    assign src_col   = CW'(src_col_w);

    assign addr_row  = is_fetch ? src_row : load_row_reg;
    assign addr_col  = is_fetch ? src_col : load_col_reg;
    assign push_addr = AW'(addr_row) * AW'(MAX_DIM) + AW'(addr_col);

    always_comb
    begin
        push_op.op   = cmd.func;
        push_op.data = cmd.element_in;
        push_op.row  = OUT_IDX_W'(emit_row_reg);
        push_op.col  = OUT_IDX_W'(emit_col_reg);
        push_op.last = emit_row_end && emit_col_end;
    end

    always_comb
    begin
        load_row_next = load_row_reg;
        load_col_next = load_col_reg;
        emit_row_next = emit_row_reg;
        emit_col_next = emit_col_reg;
        priority if (clear)
        begin
            load_row_next = '0;
            load_col_next = '0;
            emit_row_next = '0;
            emit_col_next = '0;
        end
        else if (push && !is_fetch)
        begin
            if (load_col_end)
            begin
                load_col_next = '0;
                load_row_next = load_row_end ? '0 : CW'(load_row_inc);
            end
            else
            begin
                load_col_next = CW'(load_col_inc);
            end
        end
        else if (push && is_fetch)
        begin
            if (emit_row_end && emit_col_end)
            begin
                // last element: wrap every position for the next matrix
                load_row_next = '0;
                load_col_next = '0;
                emit_row_next = '0;
                emit_col_next = '0;
            end
            else if (emit_col_end)
            begin
                emit_col_next = '0;
                emit_row_next = CW'(emit_row_inc);
            end
            else
            begin
                emit_col_next = CW'(emit_col_inc);
            end
        end
        else
        begin
            // no transaction: hold every position
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_row_reg <= '0;
            load_col_reg <= '0;
            emit_row_reg <= '0;
            emit_col_reg <= '0;
        end
        else
        begin
            load_row_reg <= load_row_next;
            load_col_reg <= load_col_next;
            emit_row_reg <= emit_row_next;
            emit_col_reg <= emit_col_next;
        end
    end

    a_load_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (DIM_W'(load_row_reg) < rows) && (DIM_W'(load_col_reg) < cols))
        else $error("load position outside matrix");

    a_emit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (DIM_W'(emit_row_reg) < cols) && (DIM_W'(emit_col_reg) < rows))
        else $error("fetch position outside rotated matrix");

    a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        clear |=> (load_row_reg == '0) && (load_col_reg == '0)
                  && (emit_row_reg == '0) && (emit_col_reg == '0))
        else $error("dimension write did not clear positions");

endmodule

@@ rtl/core/mr90_queue.sv @@
// Short FIFO between front and back of the matrix rotation unit; holds
// classified operations and their store addresses. Depends on mr90_pkg.
`timescale 1ns / 1ps

module mr90_queue
    import mr90_pkg::*;
#(
    parameter int AW = 12
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  mr90_op_t      push_op,
    input  logic [AW-1:0] push_addr,
    input  logic          pop,
    output logic          full,
    output logic          valid,
    output mr90_op_t      head_op,
    output logic [AW-1:0] head_addr
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    mr90_op_t      op_q_reg   [QUEUE_DEPTH];
    logic [AW-1:0] addr_q_reg [QUEUE_DEPTH];

    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0] count_reg,  count_next;

    assign full      = (count_reg == NW'(QUEUE_DEPTH));
    assign valid     = (count_reg != '0);
    assign head_op   = op_q_reg[rd_ptr_reg];
    assign head_addr = addr_q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + NW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - NW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            op_q_reg[wr_ptr_reg]   <= push_op;
            addr_q_reg[wr_ptr_reg] <= push_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> !pop)
        else $error("pop from empty queue");

endmodule

@@ rtl/core/mr90_back.sv @@
// Back end of the matrix rotation unit: element store, write on load, registered
// read on fetch, and the result strobe. Depends on mr90_pkg.
`timescale 1ns / 1ps

module mr90_back
    import mr90_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEFAULT,
    parameter int AW      = $clog2(MAX_DIM * MAX_DIM)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          valid,
    input  mr90_op_t      head_op,
    input  logic [AW-1:0] head_addr,
    output logic          pop,
    output logic          done,
    output mr90_out_t     result
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;

    logic [WORD_W-1:0]    mem [DEPTH];
    logic [WORD_W-1:0]    rdata_reg;
    logic [OUT_IDX_W-1:0] row_reg;
    logic [OUT_IDX_W-1:0] col_reg;
    logic                 last_reg;
    logic                 done_reg, done_next;

    // drain one operation every cycle
    assign pop       = valid;
    assign done_next = valid && (head_op.op == FUNC_FETCH);

    always_ff @(posedge clk)
    begin
        if (valid && (head_op.op == FUNC_LOAD))
        begin
            mem[head_addr] <= head_op.data;
        end
        if (done_next)
        begin
            rdata_reg <= mem[head_addr];
            row_reg   <= head_op.row;
            col_reg   <= head_op.col;
            last_reg  <= head_op.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    assign done                  = done_reg;
    assign result.element_out    = rdata_reg;
    assign result.out_row        = row_reg;
    assign result.out_col        = col_reg;
    assign result.last_of_matrix = last_reg;

    a_done_after_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(pop && (head_op.op == FUNC_FETCH)))
        else $error("result strobe without a fetch");

endmodule

@@ rtl/core/matrix_rotate_90_unit.sv @@
// Top level of the matrix rotation unit: configuration registers on an APB
// port, front end, operation queue and back end. Depends on mr90_pkg.
//
// Use:
//   Program num_rows (0x0), num_cols (0x4) and direction (0x8) over the APB
//   port while the unit is idle. Writing a dimension rewinds the load and
//   fetch positions; writing direction leaves them alone. Dimensions of 0
//   act as 1, values above MAX_DIM act as MAX_DIM.
//   Issue a transaction by raising start with cmd while busy is low. A load
//   (func = 0) stores element_in at the next row-major position of the input
//   matrix and returns nothing. A fetch (func = 1) returns the next row-major
//   element of the rotated matrix: done pulses for one cycle with result.
//   last_of_matrix marks the final element; both positions then wrap to zero.
//   Throughput: one transaction per cycle. done rises once the fetch has passed
//   the queue stage and the registered read port of the element store.
//   The receiver cannot stall; done is a one-cycle strobe and result is only
//   meaningful while it is high. busy goes high only if the queue fills.
//   Reset clears positions and registers (1 x 1, clockwise); the store is not
//   cleared, and a fetch of a never-loaded element returns an undefined word.
`timescale 1ns / 1ps

module matrix_rotate_90_unit
    import mr90_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    // command channel
    input  logic               start,
    output logic               busy,
    input  mr90_in_t           cmd,
    // result channel
    output logic               done,
    output mr90_out_t          result,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int CW    = $clog2(MAX_DIM);
    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int AW    = $clog2(MAX_DIM * MAX_DIM);
    localparam int EW    = (DIM_W > CFG_DIM_W) ? DIM_W : CFG_DIM_W;

    logic [CFG_DIM_W-1:0] num_rows_reg, num_rows_next;
    logic [CFG_DIM_W-1:0] num_cols_reg, num_cols_next;
    logic                 direction_reg, direction_next;

    reg_idx_t         reg_idx;
    logic             cfg_wr;
    logic             dim_clear;
    logic [EW-1:0]    rows_ext, cols_ext;
    logic [DIM_W-1:0] rows_eff, cols_eff;

    logic          q_push, q_pop, q_full, q_valid;
    mr90_op_t      q_push_op, q_head_op;
    logic [AW-1:0] q_push_addr, q_head_addr;

    // ---------------------------------------------------------------
    // Configuration registers: two-phase write, always ready
    // ---------------------------------------------------------------
    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        num_rows_next  = num_rows_reg;
        num_cols_next  = num_cols_reg;
        direction_next = direction_reg;
        dim_clear      = 1'b0;
        if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_NUM_ROWS:
                begin
                    num_rows_next = pwdata[CFG_DIM_W-1:0];
                    dim_clear     = 1'b1;
                end
                REG_NUM_COLS:
                begin
                    num_cols_next = pwdata[CFG_DIM_W-1:0];
                    dim_clear     = 1'b1;
                end
                REG_DIRECTION:
                begin
                    direction_next = pwdata[0];
                end
                default:
                begin
                    // unmapped address: drop the write
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_NUM_ROWS:  prdata = PDATA_W'(num_rows_reg);
            REG_NUM_COLS:  prdata = PDATA_W'(num_cols_reg);
            REG_DIRECTION: prdata = PDATA_W'(direction_reg);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg  <= CFG_DIM_W'(1);
            num_cols_reg  <= CFG_DIM_W'(1);
            direction_reg <= 1'b0;
        end
        else
        begin
            num_rows_reg  <= num_rows_next;
            num_cols_reg  <= num_cols_next;
            direction_reg <= direction_next;
        end
    end

    // Clamp dimensions to 1..MAX_DIM
    assign rows_ext = EW'(num_rows_reg);
    assign cols_ext = EW'(num_cols_reg);
    assign rows_eff = (rows_ext == '0) ? DIM_W'(1) :
                      (rows_ext > EW'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(rows_ext);
    assign cols_eff = (cols_ext == '0) ? DIM_W'(1) :
                      (cols_ext > EW'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(cols_ext);

    // ---------------------------------------------------------------
    // Front: accept and classify, hold positions, form addresses
    // ---------------------------------------------------------------
    mr90_front #(
        .MAX_DIM (MAX_DIM),
        .CW      (CW),
        .DIM_W   (DIM_W),
        .AW      (AW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (cmd),
        .full      (q_full),
        .rows      (rows_eff),
        .cols      (cols_eff),
        .dir       (direction_reg),
        .clear     (dim_clear),
        .push      (q_push),
        .push_op   (q_push_op),
        .push_addr (q_push_addr)
    );

    assign busy = q_full;

    // ---------------------------------------------------------------
    // Queue between front and back
    // ---------------------------------------------------------------
    mr90_queue #(
        .AW (AW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_op   (q_push_op),
        .push_addr (q_push_addr),
        .pop       (q_pop),
        .full      (q_full),
        .valid     (q_valid),
        .head_op   (q_head_op),
        .head_addr (q_head_addr)
    );

    // ---------------------------------------------------------------
    // Back: element store and result strobe
    // ---------------------------------------------------------------
    mr90_back #(
        .MAX_DIM (MAX_DIM),
        .AW      (AW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid     (q_valid),
        .head_op   (q_head_op),
        .head_addr (q_head_addr),
        .pop       (q_pop),
        .done      (done),
        .result    (result)
    );

endmodule

@@ dv/matrix_rotate_90_unit_tb.sv @@
// Testbench for matrix_rotate_90_unit: loads matrices, fetches them back rotated
// and checks every fetched element against a rotation predictor kept here.
// Depends on mr90_pkg and the matrix_rotate_90_unit RTL; needs nothing else.
`timescale 1ns / 1ps

module matrix_rotate_90_unit_tb;
    import mr90_pkg::*;

    localparam int DIM_MAX       = MAX_DIM_DEFAULT;
    localparam int STORE_WORDS   = DIM_MAX * DIM_MAX;
    localparam int QUIET_LIMIT   = 2000;  // cycles with no transaction at all
    localparam int SETTLE_CYCLES = 4;     // a load gives no strobe; let it reach the element store
    localparam int RANDOM_ITEMS  = 1300;
    localparam int MAX_REPORTS   = 10;
    localparam int IDLE_PCT      = 20;

    localparam logic DIR_CW  = 1'b0;
    localparam logic DIR_CCW = 1'b1;

    typedef enum logic
    {
        STEP_ITEM,
        STEP_CFG
    } step_kind_t;

    // One row of the directed table: either a command or a register write
    typedef struct packed
    {
        step_kind_t            kind;
        func_t                 func;
        logic [WORD_W-1:0]     data;
        reg_idx_t              reg_sel;
        logic [CFG_DIM_W-1:0]  value;
        logic                  typed;
        mr90_out_t             want;
    } step_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    mr90_in_t           cmd;
    logic               done;
    mr90_out_t          result;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    matrix_rotate_90_unit dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .cmd     (cmd),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial clk = 1'b0;

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Rotation predictor: its own copy of the element store, the register
    // values and the load and fetch positions.
    // ------------------------------------------------------------------
    logic [WORD_W-1:0]    rot_store [STORE_WORDS];
    bit                   rot_written [STORE_WORDS];
    logic [CFG_DIM_W-1:0] rows_cfg = 7'd1;
    logic [CFG_DIM_W-1:0] cols_cfg = 7'd1;
    logic                 dir_cfg  = DIR_CW;
    int                   wr_r = 0;
    int                   wr_c = 0;
    int                   rd_r = 0;
    int                   rd_c = 0;

    // Rotated elements still owed by the block, oldest first
    mr90_out_t            expected_elements [$];

    int                   mismatch_count = 0;
    int                   quiet_cycles   = 0;
    int                   idle_pct       = IDLE_PCT;

    // Set by the driver with each command: take this expectation instead of
    // the predicted one (directed rows whose answer is known by inspection)
    bit                   typed_pending = 1'b0;
    mr90_out_t            typed_want    = '0;

    // Zero acts as one, anything above DIM_MAX acts as DIM_MAX
    function automatic int eff_dim(logic [CFG_DIM_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > DIM_MAX)
            return DIM_MAX;
        return int'(v);
    endfunction

    function automatic void rewind_positions();
        wr_r = 0;
        wr_c = 0;
        rd_r = 0;
        rd_c = 0;
    endfunction

    function automatic void apply_config(reg_idx_t idx, logic [PDATA_W-1:0] value);
        unique case (idx)
            REG_NUM_ROWS:
            begin
                rows_cfg = value[CFG_DIM_W-1:0];
                rewind_positions();
            end
            REG_NUM_COLS:
            begin
                cols_cfg = value[CFG_DIM_W-1:0];
                rewind_positions();
            end
            REG_DIRECTION:
                dir_cfg = value[0];
            default:
                ;
        endcase
    endfunction

    // Store word that the next fetch reads
    function automatic int fetch_source();
        int rows;
        int cols;
        int k;
        int l;
        rows = eff_dim(rows_cfg);
        cols = eff_dim(cols_cfg);
        k = (rd_r < cols) ? rd_r : cols - 1;
        l = (rd_c < rows) ? rd_c : rows - 1;
        if (dir_cfg == DIR_CW)
            return (rows - 1 - l) * DIM_MAX + k;
        return l * DIM_MAX + (cols - 1 - k);
    endfunction

    function automatic void store_element(logic [WORD_W-1:0] data);
        int rows;
        int cols;
        int r;
        int c;
        rows = eff_dim(rows_cfg);
        cols = eff_dim(cols_cfg);
        r = (wr_r < rows) ? wr_r : rows - 1;
        c = (wr_c < cols) ? wr_c : cols - 1;
        rot_store[r * DIM_MAX + c]   = data;
        rot_written[r * DIM_MAX + c] = 1'b1;
        if (c + 1 >= cols)
        begin
            wr_c = 0;
            wr_r = (r + 1 >= rows) ? 0 : r + 1;
        end
        else
        begin
            wr_c = c + 1;
            wr_r = r;
        end
    endfunction

    function automatic mr90_out_t rotate_fetch();
        mr90_out_t o;
        int        rows;
        int        cols;
        int        k;
        int        l;
        rows = eff_dim(rows_cfg);
        cols = eff_dim(cols_cfg);
        k = (rd_r < cols) ? rd_r : cols - 1;
        l = (rd_c < rows) ? rd_c : rows - 1;
        o.element_out    = rot_store[fetch_source()];
        o.out_row        = OUT_IDX_W'(k);
        o.out_col        = OUT_IDX_W'(l);
        o.last_of_matrix = (k + 1 >= cols) && (l + 1 >= rows);
        // After the last element both positions wrap for the next matrix
        if (o.last_of_matrix)
            rewind_positions();
        else if (l + 1 >= rows)
        begin
            rd_c = 0;
            rd_r = k + 1;
        end
        else
        begin
            rd_c = l + 1;
            rd_r = k;
        end
        return o;
    endfunction

    function automatic void flag_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t: %s", $realtime, msg);
    endfunction

    // ------------------------------------------------------------------
    // Monitor: everything is sampled at the rising edge, before the block's
    // registers move. Check results first, then take in new transactions,
    // so an expectation is always queued ahead of its result.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        mr90_out_t want;
        bit        moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (done)
            begin
                moved = 1'b1;
                if (expected_elements.size() == 0)
                    flag_mismatch($sformatf("unexpected result: %h/%0d/%0d/%b",
                        result.element_out, result.out_row, result.out_col,
                        result.last_of_matrix));
                else
                begin
                    want = expected_elements.pop_front();
                    if (result.element_out !== want.element_out ||
                        result.out_row !== want.out_row ||
                        result.out_col !== want.out_col ||
                        result.last_of_matrix !== want.last_of_matrix)
                        flag_mismatch($sformatf(
                            "mismatch: expected %h/%0d/%0d/%b, got %h/%0d/%0d/%b",
                            want.element_out, want.out_row, want.out_col,
                            want.last_of_matrix,
                            result.element_out, result.out_row, result.out_col,
                            result.last_of_matrix));
                end
            end
            if (psel && penable && pwrite && pready)
            begin
                moved = 1'b1;
                apply_config(reg_idx_t'(paddr[PADDR_W-1:2]), pwdata);
            end
            if (start && !busy)
            begin
                moved = 1'b1;
                if (cmd.func == FUNC_FETCH)
                begin
                    want = rotate_fetch();
                    if (typed_pending)
                        want = typed_want;
                    expected_elements.push_back(want);
                end
                else
                    store_element(cmd.element_in);
            end
            // Watchdog: end the run if nothing moves for too long
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Drivers. Every task is entered and left at a falling edge.
    // ------------------------------------------------------------------

    // Issue one transaction, with random idle cycles ahead of it; hold it
    // until the block takes it.
    task automatic drive_item(func_t f, logic [WORD_W-1:0] data, bit typed, mr90_out_t want);
        mr90_in_t next_cmd;
        while (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        next_cmd.func       = f;
        next_cmd.element_in = data;
        typed_pending = typed;
        typed_want    = want;
        start <= 1'b1;
        cmd   <= next_cmd;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    // Drop start and wait for every owed result
    task automatic drain_results();
        start <= 1'b0;
        while (expected_elements.size() != 0)
            @(negedge clk);
    endtask

    // Drain, then let a trailing load leave the pipeline before touching registers
    task automatic quiesce();
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic apb_write(reg_idx_t reg_sel, logic [CFG_DIM_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({reg_sel, 2'b00});
        pwdata  <= PDATA_W'(value);
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [WORD_W-1:0] random_word();
        unique case ($urandom_range(15))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Mostly small sides; now and then zero or a value of DIM_MAX or more
    function automatic logic [CFG_DIM_W-1:0] pick_dim();
        int roll;
        roll = $urandom_range(99);
        if (roll < 5)
            return '0;
        if (roll < 10)
            return CFG_DIM_W'($urandom_range(DIM_MAX, 127));
        return CFG_DIM_W'($urandom_range(1, 6));
    endfunction

    // Random command; a fetch whose source word was never loaded turns into a load
    task automatic issue(func_t f);
        func_t eff_f;
        eff_f = f;
        if (eff_f == FUNC_FETCH && !rot_written[fetch_source()])
            eff_f = FUNC_LOAD;
        drive_item(eff_f, random_word(), 1'b0, '0);
    endtask

    function automatic step_t load_row(logic [WORD_W-1:0] data);
        step_t s;
        s         = '0;
        s.kind    = STEP_ITEM;
        s.func    = FUNC_LOAD;
        s.data    = data;
        return s;
    endfunction

    // A 1 x 1 matrix fetch is always row 0, column 0, last
    function automatic step_t fetch_row(bit typed, logic [WORD_W-1:0] elem);
        step_t s;
        s                     = '0;
        s.kind                = STEP_ITEM;
        s.func                = FUNC_FETCH;
        s.data                = 32'h5A5A_A5A5;
        s.typed               = typed;
        s.want.element_out    = elem;
        s.want.last_of_matrix = 1'b1;
        return s;
    endfunction

    function automatic step_t cfg_row(reg_idx_t reg_sel, logic [CFG_DIM_W-1:0] value);
        step_t s;
        s         = '0;
        s.kind    = STEP_CFG;
        s.func    = FUNC_LOAD;
        s.reg_sel = reg_sel;
        s.value   = value;
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        step_t                steps [$];
        int                   random_items;
        int                   phase;
        int                   n;
        int                   mode;
        logic [CFG_DIM_W-1:0] rows_raw;
        logic [CFG_DIM_W-1:0] cols_raw;

        rst_n   = 1'b0;
        start   = 1'b0;
        cmd     = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;

        // Directed part. Reset leaves a 1 x 1 clockwise matrix, so each fetch
        // returns the last load, flagged as the last element.
        steps.push_back(load_row(32'h8000_0000));
        steps.push_back(fetch_row(1'b1, 32'h8000_0000));
        steps.push_back(load_row(32'h7FFF_FFFF));
        steps.push_back(fetch_row(1'b1, 32'h7FFF_FFFF));
        // Loading past the end wraps and overwrites
        steps.push_back(load_row(32'h5555_5555));
        steps.push_back(load_row(32'hAAAA_AAAA));
        steps.push_back(fetch_row(1'b1, 32'hAAAA_AAAA));
        steps.push_back(cfg_row(REG_DIRECTION, CFG_DIM_W'(DIR_CCW)));
        steps.push_back(load_row(32'hFFFF_FFFF));
        steps.push_back(fetch_row(1'b1, 32'hFFFF_FFFF));
        // Zero columns acts as one: a 2 x 1 matrix, rotated to 1 x 2
        steps.push_back(cfg_row(REG_NUM_ROWS, 7'd2));
        steps.push_back(cfg_row(REG_NUM_COLS, 7'd0));
        steps.push_back(load_row(32'h0000_0011));
        steps.push_back(load_row(32'h0000_0022));
        steps.push_back(fetch_row(1'b0, '0));
        steps.push_back(fetch_row(1'b0, '0));
        // Rewriting a dimension mid-load rewinds the positions
        steps.push_back(cfg_row(REG_NUM_COLS, 7'd2));
        steps.push_back(load_row(32'h0000_0010));
        steps.push_back(load_row(32'h0000_0020));
        steps.push_back(load_row(32'h0000_0030));
        steps.push_back(cfg_row(REG_NUM_COLS, 7'd2));
        steps.push_back(load_row(32'h0000_0040));
        steps.push_back(load_row(32'h0000_0050));
        steps.push_back(load_row(32'h0000_0060));
        steps.push_back(load_row(32'h0000_0070));
        steps.push_back(fetch_row(1'b0, '0));
        steps.push_back(fetch_row(1'b0, '0));
        // Changing direction mid-matrix keeps the fetch position
        steps.push_back(cfg_row(REG_DIRECTION, CFG_DIM_W'(DIR_CW)));
        steps.push_back(fetch_row(1'b0, '0));
        steps.push_back(fetch_row(1'b0, '0));

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (steps[i])
        begin
            if (steps[i].kind == STEP_CFG)
            begin
                quiesce();
                apb_write(steps[i].reg_sel, steps[i].value);
            end
            else
                drive_item(steps[i].func, steps[i].data, steps[i].typed, steps[i].want);
        end

        // Random part: one register setting per phase. The first phases
        // take the extreme shapes; a few of them run with no idle cycles.
        random_items = 0;
        phase        = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            unique case (phase)
                0:
                begin
                    rows_raw = 7'd64;
                    cols_raw = 7'd1;
                end
                1:
                begin
                    rows_raw = 7'd1;
                    cols_raw = 7'd64;
                end
                2:
                begin
                    rows_raw = 7'd0;
                    cols_raw = 7'd127;
                end
                3:
                begin
                    rows_raw = 7'd127;
                    cols_raw = 7'd2;
                end
                4:
                begin
                    rows_raw = 7'd3;
                    cols_raw = 7'd0;
                end
                default:
                begin
                    rows_raw = pick_dim();
                    cols_raw = pick_dim();
                    if (eff_dim(rows_raw) > 6 && eff_dim(cols_raw) > 6)
                        cols_raw = CFG_DIM_W'($urandom_range(1, 3));
                end
            endcase
            idle_pct = (phase >= 2 && phase <= 4) ? 0 : IDLE_PCT;

            quiesce();
            apb_write(REG_DIRECTION, CFG_DIM_W'($urandom_range(1)));
            // Sometimes keep the old shape and its positions mid-matrix
            if (phase < 5 || $urandom_range(4) != 0)
            begin
                apb_write(REG_NUM_ROWS, rows_raw);
                apb_write(REG_NUM_COLS, cols_raw);
            end

            n    = eff_dim(rows_cfg) * eff_dim(cols_cfg);
            mode = $urandom_range(99);
            if (mode < 75)
            begin
                // Whole matrices: load every element, then fetch them all
                repeat ($urandom_range(1, 2))
                begin
                    repeat (n)
                    begin
                        issue(FUNC_LOAD);
                        random_items++;
                    end
                    // Hold off the sender until the block has caught up
                    if (phase == 0 || $urandom_range(3) == 0)
                        drain_results();
                    repeat (n)
                    begin
                        issue(FUNC_FETCH);
                        random_items++;
                    end
                end
            end
            else
            begin
                // Broken sequences: loads and fetches mixed at random
                repeat ($urandom_range(4, 2 * n + 4))
                begin
                    issue(func_t'($urandom_range(1)));
                    random_items++;
                end
            end
            phase++;
        end

        drain_results();
        repeat (8) @(posedge clk);
        if (expected_elements.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", expected_elements.size()));

        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
